FILE: rtl/esoc_pkg.sv
// shared constants and types for the observer controller
package esoc_pkg;

  localparam int WordBitsDef = 32;
  localparam int FracBitsDef = 16;
  localparam int RecipShift  = 62;
  localparam int CfgAddrBits = 5;

  typedef enum logic [2:0] {
    REG_ORDER  = 3'd0,
    REG_BW     = 3'd1,
    REG_PROP   = 3'd2,
    REG_DERIV  = 3'd3,
    REG_TSTEP  = 3'd4,
    REG_B0     = 3'd5,
    REG_DMAX   = 3'd6,
    REG_DMIN   = 3'd7
  } reg_idx_t;

  localparam logic [1:0] LIM_NONE = 2'd0;
  localparam logic [1:0] LIM_MAX  = 2'd1;
  localparam logic [1:0] LIM_MIN  = 2'd2;

  // request to the shared multiplier
  typedef struct packed {
    logic              start;
    logic signed [64:0] a;
    logic signed [64:0] b;
    logic [6:0]        shift;
  } mul_req_t;

endpackage

FILE: rtl/esoc_if.sv
// valid/ready channel carrying a payload of generic type
interface esoc_if #(
  parameter type payload_t = logic
) (
  input logic clk
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/esoc_mul.sv
// multi-cycle signed multiply with floor shift and word saturation
module esoc_mul
  import esoc_pkg::*;
#(
  parameter int WORD_BITS = WordBitsDef
) (
  input  logic                        clk,
  input  logic                        rst,
  input  mul_req_t                    req,
  output logic                        done,
  output logic signed [WORD_BITS-1:0] result
);
  // magnitude multiply, 16 bits of b per cycle, then shift and saturate
  localparam int StepBits = 16;
  localparam int Steps = 4;

  logic [63:0]  ma;
  logic [63:0]  mb;
  logic [127:0] acc;
  logic         neg;
  logic [6:0]   shift;
  logic [2:0]   step;
  logic         busy;
  logic         fin;

  logic [127:0] part;
  logic [127:0] q;
  logic         rem;
  logic [127:0] mask;
  logic signed [WORD_BITS-1:0] res_next;

  localparam logic [127:0] WMaxU = (128'd1 << (WORD_BITS - 1)) - 128'd1;

  always_comb begin
    part = 128'(ma * 64'(mb[StepBits-1:0])) << (StepBits * step);
    mask = (128'd1 << shift) - 128'd1;
    q = acc >> shift;
    rem = |(acc & mask);
    if (!neg) begin
      res_next = (q > WMaxU) ? WORD_BITS'(WMaxU) : WORD_BITS'(q);
    end else if (q > WMaxU) begin
      res_next = ~WORD_BITS'(WMaxU);
    end else begin
      res_next = WORD_BITS'(-$signed({1'b0, q + 128'(rem)}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        fin <= 1'b0;
        step <= '0;
        neg <= req.a[64] ^ req.b[64];
        ma <= req.a[64] ? 64'(-req.a) : 64'(req.a);
        mb <= req.b[64] ? 64'(-req.b) : 64'(req.b);
        shift <= req.shift;
        acc <= '0;
      end else if (busy) begin
        acc <= acc + part;
        mb <= mb >> StepBits;
        step <= step + 3'd1;
        if (step == 3'(Steps - 1)) begin
          busy <= 1'b0;
          fin <= 1'b1;
        end
      end else if (fin) begin
        fin <= 1'b0;
        done <= 1'b1;
        result <= res_next;
      end
    end
  end
endmodule

FILE: rtl/esoc_div.sv
// restoring divider for the reciprocal of the plant gain
module esoc_div
  import esoc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [30:0] divisor,
  output logic        busy,
  output logic [62:0] quotient
);
  // one quotient bit per cycle over a 63 bit dividend of 2^62
  logic [31:0] rem;
  logic [5:0]  cnt;
  logic [32:0] trial;
  logic        bit_in;

  always_comb begin
    bit_in = (cnt == 6'd62);
    trial = {rem, bit_in} - {2'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= 6'd62;
      rem <= '0;
      quotient <= '0;
    end else if (busy) begin
      if (!trial[32]) begin
        rem <= trial[31:0];
        quotient <= {quotient[61:0], 1'b1};
      end else begin
        rem <= {rem[30:0], bit_in};
        quotient <= {quotient[61:0], 1'b0};
      end
      if (cnt == 6'd0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 6'd1;
      end
    end
  end
endmodule

FILE: rtl/extended_state_observer_controller.sv
// top level: config registers, gain setup and the observer step sequencer
// Every product in the gain setup and the observer step goes in turn through
// one shared multiply unit. A request needs 8 products in first order and 10
// in second order, and one more product when the drive is clamped and the
// excess is fed back into the disturbance estimate. The result waits in its
// own output register, so the next request is taken while it waits; the
// block stalls only if a finished step finds the previous result still not
// taken. After reset and after every configuration write the gains are
// recomputed (four products plus a reciprocal division of 2^62 by the plant
// gain); input is not taken meanwhile. pready is always high.
module extended_state_observer_controller
  import esoc_pkg::*;
#(
  parameter int WORD_BITS = WordBitsDef,
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [CfgAddrBits-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  esoc_if.sink        in_ch,
  esoc_if.source      out_ch
);
  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [64:0] wide_t;
  localparam logic signed [64:0] WMax = (65'sd1 <<< (WORD_BITS - 1)) - 65'sd1;
  localparam logic signed [64:0] WMin = -WMax - 65'sd1;

  typedef enum logic [5:0] {
    S_RESET, S_G_WW, S_G_KP, S_G_KD, S_G_B3, S_G_DIV, S_IDLE,
    S_E, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8, S_M9,
    S_L1, S_L2, S_U, S_AW, S_OUT
  } state_t;

  state_t state;
  logic [31:0] r_order_dummy;
  logic        observer_order;
  logic [30:0] bandwidth, prop_factor, deriv_factor, plant_gain;
  logic [31:0] time_step, drive_max, drive_min;
  word_t kp, kd, beta1, beta2, beta3, w2;
  logic [62:0] recip;
  word_t z1, z2, z3, last_drive;
  word_t tgt, meas, e, t1, t2, t3, law, unclamped;
  word_t p;
  wide_t tw;
  word_t drive_r;
  logic [1:0] lim_r;
  logic  waiting;
  logic  cfg_wr;

  mul_req_t mreq;
  logic     mdone;
  word_t    mres;
  logic     div_start, div_busy;
  logic [62:0] quot;
  logic [30:0] b0;

  assign pready = 1'b1;
  assign r_order_dummy = {31'b0, observer_order};
  assign b0 = (plant_gain == '0) ? 31'd1 : plant_gain;

  // a config write drops any product still in flight
  esoc_mul #(.WORD_BITS(WORD_BITS)) u_mul (
    .clk(clk), .rst(rst || cfg_wr), .req(mreq), .done(mdone), .result(mres)
  );
  esoc_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .divisor(b0),
    .busy(div_busy), .quotient(quot)
  );

  function automatic word_t sat(input wide_t v);
    if (v > WMax) return word_t'(WMax);
    if (v < WMin) return word_t'(WMin);
    return word_t'(v);
  endfunction

  function automatic word_t sat_in(input logic [31:0] v);
    return sat(wide_t'($signed(v)));
  endfunction

  function automatic wide_t wx(input word_t v);
    return wide_t'(v);
  endfunction

  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (reg_idx_t'(paddr[4:2]))
      REG_ORDER: prdata = r_order_dummy;
      REG_BW:    prdata = {1'b0, bandwidth};
      REG_PROP:  prdata = {1'b0, prop_factor};
      REG_DERIV: prdata = {1'b0, deriv_factor};
      REG_TSTEP: prdata = time_step;
      REG_B0:    prdata = {1'b0, plant_gain};
      REG_DMAX:  prdata = drive_max;
      REG_DMIN:  prdata = drive_min;
      default:   prdata = '0;
    endcase
  end

  assign in_ch.ready = (state == S_IDLE) && !cfg_wr;

  // issue a product; the sequencer then waits for the multiplier result
  task automatic issue(input wide_t a, input wide_t b, input logic [6:0] s);
    mreq.start = 1'b1;
    mreq.a = a;
    mreq.b = b;
    mreq.shift = s;
  endtask

  localparam logic [6:0] FS = 7'(FRAC_BITS);
  localparam logic [6:0] TS = 7'd32;
  localparam logic [6:0] US = 7'(RecipShift - FRAC_BITS);

  wide_t wb0, wts;
  assign wb0 = wide_t'({1'b0, b0});
  assign wts = wide_t'({1'b0, time_step});

  // sequencer phases: issue when !waiting, consume when mdone
  always_comb begin
    mreq = '0;
    if (!waiting) begin
      unique case (state)
        S_G_WW: issue(wide_t'({1'b0, bandwidth}), wide_t'({1'b0, bandwidth}), FS);
        S_G_KP: issue(wide_t'({1'b0, prop_factor}), wide_t'({1'b0, bandwidth}), FS);
        S_G_KD: issue(wide_t'({1'b0, deriv_factor}), wide_t'({1'b0, bandwidth}), FS);
        S_G_B3: issue(wx(w2), wide_t'({1'b0, bandwidth}), FS);
        S_M1:   issue(wx(beta1), wx(e), FS);
        S_M2:   issue(wb0, wx(last_drive), FS);
        S_M3:   issue(wx(beta2), wx(e), FS);
        S_M4:   issue(wx(beta3), wx(e), FS);
        S_M5:   issue(wts, wx(t1), TS);
        S_M6:   issue(wts, wx(t2), TS);
        S_M7:   issue(wts, wx(observer_order ? t3 : p), TS);
        S_L1:   issue(wx(kp), wx(sat(wx(tgt) - wx(z1))), FS);
        S_L2:   issue(wx(kd), wx(sat(-wx(z2))), FS);
        S_U:    issue(wx(sat(wx(law) - wx(observer_order ? z3 : z2))),
                      wide_t'({2'b0, recip}), US);
        S_AW:   issue(wb0, wx(sat(wx(unclamped) - wx(drive_r))), FS);
        default: ;
      endcase
    end
  end

  word_t hi_lim, lo_lim;
  assign hi_lim = sat_in(drive_max);
  assign lo_lim = sat_in(drive_min);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RESET;
      waiting <= 1'b0;
      div_start <= 1'b0;
      out_ch.valid <= 1'b0;
      observer_order <= 1'b1;
      bandwidth <= 31'd655360;
      prop_factor <= 31'd65536;
      deriv_factor <= 31'd65536;
      time_step <= 32'd4294967;
      plant_gain <= 31'd65536;
      drive_max <= 32'd655360;
      drive_min <= 32'hFFF60000;
      z1 <= '0; z2 <= '0; z3 <= '0; last_drive <= '0;
    end else begin
      div_start <= 1'b0;
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      waiting <= cfg_wr ? 1'b0 : (mreq.start ? 1'b1 : (mdone ? 1'b0 : waiting));
      if (cfg_wr) begin
        unique case (reg_idx_t'(paddr[4:2]))
          REG_ORDER: observer_order <= pwdata[0];
          REG_BW:    bandwidth <= pwdata[30:0];
          REG_PROP:  prop_factor <= pwdata[30:0];
          REG_DERIV: deriv_factor <= pwdata[30:0];
          REG_TSTEP: time_step <= pwdata;
          REG_B0:    plant_gain <= pwdata[30:0];
          REG_DMAX:  drive_max <= pwdata;
          REG_DMIN:  drive_min <= pwdata;
          default: ;
        endcase
        state <= S_RESET;
      end else begin
        unique case (state)
          S_RESET: state <= S_G_WW;
          S_G_WW: if (mdone) begin
            w2 <= mres;
            if (observer_order) begin
              beta1 <= sat(3 * wide_t'({1'b0, bandwidth}));
              beta2 <= sat(3 * wx(mres));
            end else begin
              beta1 <= sat(2 * wide_t'({1'b0, bandwidth}));
              beta2 <= mres;
            end
            state <= S_G_KP;
          end
          S_G_KP: if (mdone) begin kp <= mres; state <= S_G_KD; end
          S_G_KD: if (mdone) begin kd <= mres; state <= S_G_B3; end
          S_G_B3: if (mdone) begin
            beta3 <= observer_order ? mres : '0;
            div_start <= 1'b1;
            state <= S_G_DIV;
          end
          S_G_DIV: if (!div_start && !div_busy) begin
            recip <= quot;
            state <= S_IDLE;
          end
          S_IDLE: if (in_ch.valid) begin
            tgt <= sat_in(in_ch.data.target);
            meas <= sat_in(in_ch.data.measured);
            if (in_ch.data.clear_state) begin
              z1 <= '0; z2 <= '0; z3 <= '0; last_drive <= '0;
            end
            state <= S_E;
          end
          S_E: begin e <= sat(wx(meas) - wx(z1)); state <= S_M1; end
          // three-term sums saturate once, so the partial sum stays wide
          S_M1: if (mdone) begin
            t1 <= sat(wx(z2) + wx(mres));
            tw <= wx(z2) + wx(mres);
            state <= S_M2;
          end
          S_M2: if (mdone) begin
            if (observer_order) tw <= wx(z3) + wx(mres);
            else t1 <= sat(tw + wx(mres));
            state <= S_M3;
          end
          S_M3: if (mdone) begin
            if (observer_order) t2 <= sat(tw + wx(mres));
            else p <= mres;
            state <= observer_order ? S_M4 : S_M5;
          end
          S_M4: if (mdone) begin t3 <= mres; state <= S_M5; end
          S_M5: if (mdone) begin z1 <= sat(wx(z1) + wx(mres)); state <= S_M6; end
          S_M6: if (mdone) begin
            if (observer_order) z2 <= sat(wx(z2) + wx(mres));
            state <= S_M7;
          end
          S_M7: if (mdone) begin
            if (observer_order) z3 <= sat(wx(z3) + wx(mres));
            else z2 <= sat(wx(z2) + wx(mres));
            state <= S_L1;
          end
          S_L1: if (mdone) begin
            law <= mres;
            state <= observer_order ? S_L2 : S_U;
          end
          S_L2: if (mdone) begin law <= sat(wx(law) + wx(mres)); state <= S_U; end
          S_U: if (mdone) begin
            unclamped <= mres;
            if (mres > hi_lim) begin
              drive_r <= hi_lim;
              lim_r <= LIM_MAX;
              state <= S_AW;
            end else if (mres < lo_lim) begin
              drive_r <= lo_lim;
              lim_r <= LIM_MIN;
              state <= S_AW;
            end else begin
              drive_r <= mres;
              lim_r <= LIM_NONE;
              state <= S_OUT;
            end
          end
          S_AW: if (mdone) begin
            if (observer_order) z3 <= sat(wx(z3) + wx(mres));
            else z2 <= sat(wx(z2) + wx(mres));
            state <= S_OUT;
          end
          // wait until the previous result has been taken
          S_OUT: if (!out_ch.valid) begin
            last_drive <= drive_r;
            out_ch.data.drive <= drive_r;
            out_ch.data.limit_hit <= lim_r;
            out_ch.valid <= 1'b1;
            state <= S_IDLE;
          end
          default: state <= S_RESET;
        endcase
      end
    end
  end
endmodule
